// ----- design/asmu_pkg.sv -----
`default_nettype none

package asmu_pkg;

  // Field and datapath widths
  localparam int SPD_W   = 16;
  localparam int GAIN_W  = 8;
  localparam int MULT_W  = 16;
  localparam int DRV_W   = 8;
  localparam int OP_W    = 18;
  localparam int PROD_W  = 2 * OP_W;
  localparam int ERRP_W  = 25;           // gain * error, signed
  localparam int DIV_W   = 24;           // dividend / quotient width
  localparam int DVS_W   = 16;           // divisor width
  localparam int CNT_W   = $clog2(DIV_W);
  localparam int CORR_W  = 10;           // clamped correction, signed

  // Algorithm constants
  localparam int MULT_ONE    = 256;
  localparam int ERR_CLAMP   = 256;
  localparam int POWER_LIMIT = 25600;
  localparam int GAIN_RESET  = 16;

  typedef struct packed {
    logic signed [SPD_W-1:0] goal_speed;
    logic signed [SPD_W-1:0] measured_speed;
    logic                    bump_hit;
  } asmu_in_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] power;
    logic signed [DRV_W-1:0] motor_drive;
    logic                    bump_stop;
  } asmu_out_t;

  typedef enum logic [1:0] {
    MUL_ERR,
    MUL_LIM,
    MUL_PWR
  } asmu_mul_sel_t;

  typedef enum logic {
    DIV_CORR,
    DIV_LIM
  } asmu_div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_CDIV_GO,
    S_CDIV_WAIT,
    S_SUM,
    S_LMUL,
    S_LCHK,
    S_LDIV_GO,
    S_LDIV_WAIT,
    S_PMUL,
    S_DONE
  } asmu_state_t;

  typedef struct packed {
    logic          load_in;
    logic          do_mul;
    asmu_mul_sel_t mul_sel;
    logic          div_start;
    asmu_div_sel_t div_sel;
    logic          take_sum;
    logic          take_lim;
    logic          load_out;
  } asmu_cmd_t;

  typedef struct packed {
    logic bump_stop;
    logic tgt_zero;
    logic over_limit;
    logic div_busy;
    logic out_free;
  } asmu_stat_t;

endpackage

`default_nettype wire

// ----- design/asmu_div.sv -----
`default_nettype none

module asmu_div import asmu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic [DIV_W-1:0]      quotient
);

  logic [DVS_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_diff;
  logic             fits;

  // Restoring division, one quotient bit per cycle
  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign fits     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ----- design/asmu_ctrl.sv -----
`default_nettype none

module asmu_ctrl import asmu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire asmu_stat_t stat,
  output asmu_cmd_t       cmd
);

  asmu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PROD;
      end
      S_PROD: begin
        if (stat.bump_stop)     state_next = S_DONE;
        else if (stat.tgt_zero) state_next = S_SUM;
        else                    state_next = S_CDIV_GO;
      end
      S_CDIV_GO:   state_next = S_CDIV_WAIT;
      S_CDIV_WAIT: begin
        if (!stat.div_busy) state_next = S_SUM;
      end
      S_SUM:  state_next = S_LMUL;
      S_LMUL: state_next = S_LCHK;
      S_LCHK: begin
        state_next = stat.over_limit ? S_LDIV_GO : S_PMUL;
      end
      S_LDIV_GO:   state_next = S_LDIV_WAIT;
      S_LDIV_WAIT: begin
        if (!stat.div_busy) state_next = S_PMUL;
      end
      S_PMUL: state_next = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_PROD: begin
        cmd.do_mul  = 1'b1;
        cmd.mul_sel = MUL_ERR;
      end
      S_CDIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CORR;
      end
      S_CDIV_WAIT: cmd.div_sel = DIV_CORR;
      S_SUM:       cmd.take_sum = 1'b1;
      S_LMUL: begin
        cmd.do_mul  = 1'b1;
        cmd.mul_sel = MUL_LIM;
      end
      S_LCHK: ;
      S_LDIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_LIM;
      end
      S_LDIV_WAIT: begin
        cmd.div_sel  = DIV_LIM;
        cmd.take_lim = !stat.div_busy;
      end
      S_PMUL: begin
        cmd.do_mul  = 1'b1;
        cmd.mul_sel = MUL_PWR;
      end
      S_DONE: cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/asmu_dp.sv -----
`default_nettype none

module asmu_dp import asmu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [GAIN_W-1:0] cfg_wr_data,
  input  wire asmu_in_t          in_data,
  input  wire asmu_cmd_t         cmd,
  output asmu_stat_t             stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output asmu_out_t              out_data
);

  logic [GAIN_W-1:0]        gain;
  logic [MULT_W-1:0]        gm;
  logic signed [SPD_W-1:0]  tgt;
  logic signed [SPD_W-1:0]  meas;
  logic                     bump;
  logic signed [PROD_W-1:0] mul_q;
  logic [MULT_W-1:0]        m_cur;

  logic [SPD_W-1:0]         abs_t;
  logic signed [SPD_W:0]    err;
  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic [ERRP_W-1:0]        prod;
  logic [ERRP_W-1:0]        prod_mag;
  logic [DIV_W-1:0]         div_dividend;
  logic                     div_busy;
  logic [DIV_W-1:0]         div_q;
  logic [8:0]               q_clamp;
  logic [CORR_W-1:0]        corr;
  logic [OP_W-1:0]          m_sum;
  logic [SPD_W-1:0]         pwr;
  logic [SPD_W-1:0]         pwr_adj;
  logic                     stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_W'(GAIN_RESET);
    end else if (cfg_wr_en) begin
      gain <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tgt  <= in_data.goal_speed;
      meas <= in_data.measured_speed;
      bump <= in_data.bump_hit;
    end
  end

  assign abs_t = tgt[SPD_W-1] ? (SPD_W'(0) - tgt) : tgt;
  assign err   = {tgt[SPD_W-1], tgt} - {meas[SPD_W-1], meas};
  assign stop  = bump && !tgt[SPD_W-1] && (tgt != '0);

  // Shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_ERR: begin
        mul_a = $signed({{(OP_W-GAIN_W){1'b0}}, gain});
        mul_b = $signed({err[SPD_W], err});
      end
      MUL_LIM: begin
        mul_a = $signed({{(OP_W-MULT_W){1'b0}}, m_cur});
        mul_b = $signed({{(OP_W-SPD_W){1'b0}}, abs_t});
      end
      MUL_PWR: begin
        mul_a = $signed({{(OP_W-MULT_W){1'b0}}, m_cur});
        mul_b = $signed({{(OP_W-SPD_W){tgt[SPD_W-1]}}, tgt});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      mul_q <= mul_a * mul_b;
    end
  end

  // Shared divider: |gain*err| / |target|, or the power limit / |target|
  assign prod     = mul_q[ERRP_W-1:0];
  assign prod_mag = prod[ERRP_W-1] ? (ERRP_W'(0) - prod) : prod;

  always_comb begin
    case (cmd.div_sel)
      DIV_CORR: div_dividend = prod_mag[DIV_W-1:0];
      DIV_LIM:  div_dividend = DIV_W'(POWER_LIMIT);
      default:  div_dividend = '0;
    endcase
  end

  asmu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (abs_t),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Clamp, sign and apply the correction, then floor at one
  always_comb begin
    q_clamp = (div_q > DIV_W'(ERR_CLAMP)) ? 9'(ERR_CLAMP) : div_q[8:0];
    if (tgt == '0) begin
      corr = '0;
    end else if (prod[ERRP_W-1] ^ tgt[SPD_W-1]) begin
      corr = CORR_W'(0) - {1'b0, q_clamp};
    end else begin
      corr = {1'b0, q_clamp};
    end
    m_sum = {2'b00, gm} + {{(OP_W-CORR_W){corr[CORR_W-1]}}, corr};
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sum) begin
      if (m_sum[OP_W-1] || (m_sum == '0)) begin
        m_cur <= MULT_W'(1);
      end else begin
        m_cur <= m_sum[MULT_W-1:0];
      end
    end else if (cmd.take_lim) begin
      m_cur <= div_q[MULT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gm <= MULT_W'(MULT_ONE);
    end else if (cmd.load_out && !stop) begin
      gm <= m_cur;
    end
  end

  // Divide by 256 toward zero
  assign pwr     = mul_q[SPD_W-1:0];
  assign pwr_adj = pwr + (pwr[SPD_W-1] ? SPD_W'(255) : SPD_W'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.bump_stop <= stop;
      if (stop) begin
        out_data.power       <= '0;
        out_data.motor_drive <= '0;
      end else begin
        out_data.power       <= pwr;
        out_data.motor_drive <= pwr_adj[SPD_W-1:SPD_W-DRV_W];
      end
    end
  end

  assign stat.bump_stop  = stop;
  assign stat.tgt_zero   = (tgt == '0);
  assign stat.over_limit = $unsigned(mul_q) > PROD_W'(POWER_LIMIT);
  assign stat.div_busy   = div_busy;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- design/adaptive_speed_multiplier_unit.sv -----
// Adaptive speed multiplier: one drive command per control tick.
//
// Input channel (in_valid/in_ready/in_data) carries target speed, measured
// speed and the bump flag. Output channel (out_valid/out_ready/out_data)
// carries power, motor drive and the bump-stop flag, exactly one transfer per
// input transfer. cfg_wr_en/cfg_wr_data write the error gain; write it only
// while the block is idle.
//
// Steps per input: error product, correction divide, sum, limit product,
// limit check, limit divide, power product. A bump stop skips to the
// output, a zero target skips the correction divide and the limit divide
// runs only when the power limit is hit. in_ready is high only while the
// controller is idle, so the next item waits until this one is done.
//
// A finished result sits in the output register; the block returns to idle
// and takes the next item while that result waits. If the receiver still
// stalls when the next result is ready, hold it in the datapath until the
// output register frees up.
//
// Reset (rst, synchronous): multiplier back to 256 (1.0), gain back to 16,
// output register empty, controller idle.
`default_nettype none

module adaptive_speed_multiplier_unit import asmu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire asmu_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output asmu_out_t              out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [GAIN_W-1:0] cfg_wr_data
);

  asmu_cmd_t  cmd;
  asmu_stat_t stat;

  // Sequence the multiply / divide steps
  asmu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Multiplier state, shared multiplier and divider, output register
  asmu_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/asmu_drive_checker.sv -----
`timescale 1ns / 1ps

module asmu_drive_checker import asmu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  asmu_in_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  asmu_out_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [GAIN_W-1:0] cfg_wr_data,
  output int                drive_errors,
  output int                drives_pending
);

  asmu_out_t expected_drives[$];
  longint    multiplier;
  longint    error_gain;

  initial begin
    drive_errors   = 0;
    drives_pending = 0;
  end

  // Advance the multiplier by one tick and return the drive command it yields.
  function automatic asmu_out_t predict_drive(asmu_in_t tick);
    longint    tgt;
    longint    meas;
    longint    abs_tgt;
    longint    corr;
    longint    mult;
    longint    pwr;
    longint    drv;
    asmu_out_t res;
    tgt  = $signed(tick.goal_speed);
    meas = $signed(tick.measured_speed);
    res  = '0;
    if (tgt > 0 && tick.bump_hit) begin
      res.bump_stop = 1'b1;
    end else begin
      mult    = multiplier;
      abs_tgt = (tgt < 0) ? -tgt : tgt;
      if (tgt != 0) begin
        corr = (error_gain * (tgt - meas)) / tgt;
        if (corr > ERR_CLAMP) corr = ERR_CLAMP;
        if (corr < -ERR_CLAMP) corr = -ERR_CLAMP;
        mult = mult + corr;
      end
      if (mult < 1) mult = 1;
      if (mult * abs_tgt > POWER_LIMIT) mult = POWER_LIMIT / abs_tgt;
      multiplier      = mult;
      pwr             = mult * tgt;
      drv             = pwr / 256;
      res.power       = pwr[SPD_W-1:0];
      res.motor_drive = drv[DRV_W-1:0];
    end
    return res;
  endfunction

  task automatic check_drive(asmu_out_t got);
    asmu_out_t want;
    if (expected_drives.size() == 0) begin
      drive_errors++;
      $display("%0t: unexpected drive power %0d drive %0d stop %0b", $time,
               $signed(got.power), $signed(got.motor_drive), got.bump_stop);
    end else begin
      want = expected_drives.pop_front();
      if (got.power !== want.power || got.motor_drive !== want.motor_drive ||
          got.bump_stop !== want.bump_stop) begin
        drive_errors++;
        $display("%0t: mismatch power exp %0d got %0d, drive exp %0d got %0d, stop %0b/%0b",
                 $time, $signed(want.power), $signed(got.power),
                 $signed(want.motor_drive), $signed(got.motor_drive),
                 want.bump_stop, got.bump_stop);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      multiplier = MULT_ONE;
      error_gain = GAIN_RESET;
      expected_drives.delete();
    end else begin
      if (cfg_wr_en) error_gain = cfg_wr_data;
      if (in_valid && in_ready) expected_drives.push_back(predict_drive(in_data));
      if (out_valid && out_ready) check_drive(out_data);
    end
    drives_pending = expected_drives.size();
  end

endmodule

// ----- tb/tb_adaptive_speed_multiplier_unit.sv -----
`timescale 1ns / 1ps

module tb_adaptive_speed_multiplier_unit;
  import asmu_pkg::*;

  // Covers the slowest item, the random idle gaps on each side and the long
  // receiver hold-offs; take that several times over.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_WAIT  = 64;
  localparam int PHASE_TICKS  = 112;
  localparam int PHASE_COUNT  = 7;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  asmu_in_t          in_data;
  logic              out_valid;
  logic              out_ready;
  asmu_out_t         out_data;
  logic              cfg_wr_en;
  logic [GAIN_W-1:0] cfg_wr_data;

  int drive_errors;
  int drives_pending;
  int cycle_count;

  // Shared knobs between the sender and the receiver process.
  bit no_idle;
  bit hold_off_req;

  adaptive_speed_multiplier_unit uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  asmu_drive_checker drive_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .drive_errors   (drive_errors),
    .drives_pending (drives_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one tick: idle for a random gap, then hold valid and payload
  // until the transfer. Valid stays high on return so back-to-back ticks
  // need no extra edge.
  task automatic send_tick(asmu_in_t tick);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_values(int tgt, int meas, bit bump);
    asmu_in_t tick;
    tick.goal_speed     = tgt[SPD_W-1:0];
    tick.measured_speed = meas[SPD_W-1:0];
    tick.bump_hit       = bump;
    send_tick(tick);
  endtask

  // Drop valid and wait until every expected drive command has come back.
  // Sample the count at the falling edge, away from the checker's update.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (drives_pending != 0);
    @(posedge clk);
  endtask

  // Write the error gain only once the block has gone idle.
  task automatic write_gain(int gain);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= gain[GAIN_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Targets are small, within the power limit, zero, at the power limit or
  // anywhere in range; half the measured speeds lie near the target so the
  // multiplier wanders over its whole range, the rest are wild readings.
  function automatic asmu_in_t random_tick();
    int       tgt;
    int       meas;
    int       span;
    int       pick;
    asmu_in_t tick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      tgt = $urandom_range(0, 400) - 200;
    else if (pick < 70) tgt = $urandom_range(0, 2 * POWER_LIMIT) - POWER_LIMIT;
    else if (pick < 80) tgt = 0;
    else if (pick < 90) tgt = $urandom_range(0, 1) ? POWER_LIMIT : -POWER_LIMIT;
    else                tgt = $urandom_range(0, 65535) - 32768;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      span = 1 + ((tgt < 0) ? -tgt : tgt) / 8;
      meas = tgt + $urandom_range(0, 2 * span) - span;
      if (meas > 32767) meas = 32767;
      if (meas < -32768) meas = -32768;
    end else if (pick < 80) begin
      meas = $urandom_range(0, 65535) - 32768;
    end else begin
      case ($urandom_range(0, 3))
        0:       meas = -32768;
        1:       meas = 32767;
        2:       meas = 0;
        default: meas = (tgt == -32768) ? 32767 : -tgt;
      endcase
    end
    tick.goal_speed     = tgt[SPD_W-1:0];
    tick.measured_speed = meas[SPD_W-1:0];
    tick.bump_hit       = ($urandom_range(0, 3) == 0);
    return tick;
  endfunction

  // Receiver: stall a random number of cycles before each transfer, and
  // on request hold off for a long stretch so the block backs up.
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int phase_gain [PHASE_COUNT];
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    no_idle      = 1'b0;
    hold_off_req = 1'b0;
    phase_gain[0] = 255;
    phase_gain[1] = 0;
    phase_gain[2] = 1;
    phase_gain[3] = 128;
    phase_gain[4] = $urandom_range(2, 254);
    phase_gain[5] = $urandom_range(2, 254);
    phase_gain[6] = GAIN_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at the reset gain.
    send_values(100, 100, 1'b0);            // no error, multiplier holds
    send_values(100, 0, 1'b0);              // positive error
    send_values(100, -32768, 1'b0);         // correction clamps high
    send_values(100, 32767, 1'b0);          // correction clamps low
    send_values(1, -32768, 1'b0);
    send_values(-1, 32767, 1'b0);
    send_values(0, 500, 1'b0);              // zero target, no correction
    send_values(0, 0, 1'b1);                // bump ignored on zero target
    send_values(-100, -50, 1'b1);           // bump ignored on reverse
    send_values(100, 100, 1'b1);            // bump stop, multiplier held
    send_values(25600, 25600, 1'b0);        // power at the limit
    send_values(-25600, -25600, 1'b0);
    send_values(25600, -32768, 1'b0);
    send_values(-25600, 32767, 1'b0);
    send_values(32767, 0, 1'b0);            // beyond limit, multiplier to 0
    send_values(-32768, 32767, 1'b0);
    send_values(-32768, -32768, 1'b1);
    send_values(50, 50, 1'b0);              // floor restores multiplier
    send_values(-50, -40, 1'b0);
    send_values(200, 300, 1'b0);
    send_values(7, -7, 1'b0);
    send_values(-3, 32767, 1'b0);

    // Random phases, one gain setting each.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_gain(phase_gain[p]);
      for (int i = 0; i < PHASE_TICKS; i++) begin
        no_idle = (i >= 40 && i < 60);
        if (i == 70 && (p == 1 || p == 4)) hold_off_req = 1'b1;
        if (i == 90 && p == 2) drain_results();
        send_tick(random_tick());
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (drive_errors == 0 && drives_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/asmu_pkg.sv
design/asmu_div.sv
design/asmu_ctrl.sv
design/asmu_dp.sv
design/adaptive_speed_multiplier_unit.sv
tb/asmu_drive_checker.sv
tb/tb_adaptive_speed_multiplier_unit.sv
